FILE: src/pwmsu_pkg.sv
`default_nettype none

package pwmsu_pkg;

  localparam int CNT_W  = 32;
  localparam int RES_W  = 16;
  localparam int STEP_W = $clog2(CNT_W);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ROUND,
    ST_COMMIT
  } pwmsu_state_e;

  typedef struct packed {
    logic load_item;
    logic do_tick;
    logic div_start;
    logic div_step;
    logic do_round;
    logic do_commit;
    logic do_reject;
  } pwmsu_cmd_t;

  typedef struct packed {
    logic reject;
    logic div_last;
    logic out_free;
  } pwmsu_sts_t;

endpackage

`default_nettype wire

FILE: src/pwm_generator_shadowed_update.sv
// One-channel PWM generator with shadowed settings.
// Input channel (in_valid_i/in_ready_o) carries one item: op_i = 0 is one time
// tick, op_i = 1 applies enable_i, new_period_i, new_duty_i and invert_i.
// Every item gives exactly one result on the output channel (out_valid_o /
// out_ready_i): pin level, active, update_pending and status.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the 16-bit
// resolution; it is always ready. Write it only while the block is idle.
// Latency: a tick result is valid the cycle after acceptance, and ticks
// are taken one per cycle while results are drained. An apply passes
// through check, one remainder bit per cycle through the restoring
// rounding unit, round and commit. A rejected apply ends after check.
// A new item is taken only when the output register is empty or being
// drained in the same cycle; a stalled receiver holds the result and stops
// input acceptance.
// Reset: pin low, generator idle, no pending setting, resolution 1.
`default_nettype none

module pwm_generator_shadowed_update (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [pwmsu_pkg::RES_W-1:0] cfg_resolution_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         op_i,
  input  wire                         enable_i,
  input  wire  [pwmsu_pkg::CNT_W-1:0] new_period_i,
  input  wire  [pwmsu_pkg::CNT_W-1:0] new_duty_i,
  input  wire                         invert_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        pin_o,
  output logic                        active_o,
  output logic                        update_pending_o,
  output logic                        status_o
);
  import pwmsu_pkg::*;

  pwmsu_cmd_t cmd;
  pwmsu_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pwmsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pwmsu_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_resolution_i (cfg_resolution_i),
    .enable_i         (enable_i),
    .new_period_i     (new_period_i),
    .new_duty_i       (new_duty_i),
    .invert_i         (invert_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pin_o            (pin_o),
    .active_o         (active_o),
    .update_pending_o (update_pending_o),
    .status_o         (status_o)
  );

endmodule

`default_nettype wire

FILE: src/pwmsu_ctrl.sv
`default_nettype none

module pwmsu_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  input  wire                        op_i,
  output logic                       in_ready_o,
  input  wire pwmsu_pkg::pwmsu_sts_t sts_i,
  output pwmsu_pkg::pwmsu_cmd_t      cmd_o
);
  import pwmsu_pkg::*;

  pwmsu_state_e state_q, state_d;
  logic         accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        accept     = in_valid_i && sts_i.out_free;
        if (accept) begin
          if (op_i == OP_APPLY) begin
            cmd_o.load_item = 1'b1;
            state_d         = ST_CHECK;
          end else begin
            cmd_o.do_tick = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.reject) begin
          if (sts_i.out_free) begin
            cmd_o.do_reject = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.do_round = 1'b1;
        state_d        = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.do_commit = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input ready outside idle");

endmodule

`default_nettype wire

FILE: src/pwmsu_dp.sv
`default_nettype none

module pwmsu_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  input  wire  [pwmsu_pkg::RES_W-1:0]        cfg_resolution_i,
  input  wire                                enable_i,
  input  wire  [pwmsu_pkg::CNT_W-1:0]        new_period_i,
  input  wire  [pwmsu_pkg::CNT_W-1:0]        new_duty_i,
  input  wire                                invert_i,
  input  wire pwmsu_pkg::pwmsu_cmd_t         cmd_i,
  output pwmsu_pkg::pwmsu_sts_t              sts_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               pin_o,
  output logic                               active_o,
  output logic                               update_pending_o,
  output logic                               status_o
);
  import pwmsu_pkg::*;

  function automatic logic [RES_W-1:0] rem_step(input logic [RES_W-1:0] rem,
                                                input logic             din,
                                                input logic [RES_W-1:0] r);
    logic [RES_W:0] t;
    logic [RES_W:0] s;
    t = {rem, din};
    s = t - {1'b0, r};
    if (t >= {1'b0, r}) begin
      return s[RES_W-1:0];
    end
    return t[RES_W-1:0];
  endfunction

  logic [RES_W-1:0]  res_q;
  logic [RES_W-1:0]  eff_res;
  logic [CNT_W-1:0]  res_ext;

  logic              en_q, inv_q;
  logic [CNT_W-1:0]  per_q, duty_q, diff;

  logic [CNT_W-1:0]  shp_q, shd_q;
  logic [RES_W-1:0]  remp_q, remd_q;
  logic [STEP_W-1:0] cnt_q;
  logic [CNT_W-1:0]  rp_q, rd_q;

  logic [CNT_W-1:0]  cur_per_q, cur_per_d, cur_duty_q, cur_duty_d;
  logic [CNT_W-1:0]  sh_per_q, sh_per_d, sh_duty_q, sh_duty_d;
  logic              cur_inv_q, cur_inv_d, sh_inv_q, sh_inv_d;
  logic              phase_q, phase_d, running_q, running_d;
  logic              pending_q, pending_d, pin_q, pin_d;
  logic [CNT_W-1:0]  ticks_q, ticks_d;
  logic              status_q, status_d;
  logic              out_valid_q, out_valid_d;

  logic              load_shadow, produce, enter;
  logic [CNT_W-1:0]  ep_per, ep_duty, ep_ticks;
  logic              ep_inv, ep_level, ep_steady;

  assign eff_res = (res_q == '0) ? RES_W'(1) : res_q;
  assign res_ext = CNT_W'(eff_res);
  assign diff    = per_q - duty_q;

  assign sts_o.reject   = ((duty_q != '0) && (duty_q < res_ext)) || (duty_q > per_q)
                          || ((duty_q != per_q) && (diff < res_ext));
  assign sts_o.div_last = (cnt_q == STEP_W'(CNT_W - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= RES_W'(1);
    end else if (cfg_valid_i) begin
      res_q <= cfg_resolution_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      en_q   <= enable_i;
      per_q  <= new_period_i;
      duty_q <= new_duty_i;
      inv_q  <= invert_i;
    end
    if (cmd_i.div_start) begin
      shp_q  <= per_q;
      shd_q  <= duty_q;
      remp_q <= '0;
      remd_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      remp_q <= rem_step(remp_q, shp_q[CNT_W-1], eff_res);
      remd_q <= rem_step(remd_q, shd_q[CNT_W-1], eff_res);
      shp_q  <= {shp_q[CNT_W-2:0], 1'b0};
      shd_q  <= {shd_q[CNT_W-2:0], 1'b0};
      cnt_q  <= cnt_q + STEP_W'(1);
    end
    if (cmd_i.do_round) begin
      rp_q <= per_q - CNT_W'(remp_q);
      rd_q <= duty_q - CNT_W'(remd_q);
    end
  end

  always_comb begin
    load_shadow = !phase_q && pending_q;
    if (cmd_i.do_tick) begin
      ep_per   = load_shadow ? sh_per_q : cur_per_q;
      ep_duty  = load_shadow ? sh_duty_q : cur_duty_q;
      ep_inv   = load_shadow ? sh_inv_q : cur_inv_q;
      ep_level = load_shadow ? (sh_duty_q != '0) : !phase_q;
    end else begin
      ep_per   = rp_q;
      ep_duty  = rd_q;
      ep_inv   = inv_q;
      ep_level = (duty_q != '0);
    end
    ep_steady = (ep_duty == '0) || (ep_duty == ep_per);
    if (ep_steady) begin
      ep_ticks = '0;
    end else if (ep_level) begin
      ep_ticks = ep_duty;
    end else begin
      ep_ticks = ep_per - ep_duty;
    end
  end

  always_comb begin
    cur_per_d  = cur_per_q;
    cur_duty_d = cur_duty_q;
    cur_inv_d  = cur_inv_q;
    sh_per_d   = sh_per_q;
    sh_duty_d  = sh_duty_q;
    sh_inv_d   = sh_inv_q;
    phase_d    = phase_q;
    running_d  = running_q;
    pending_d  = pending_q;
    pin_d      = pin_q;
    ticks_d    = ticks_q;
    status_d   = status_q;
    enter      = 1'b0;
    produce    = cmd_i.do_tick || cmd_i.do_commit || cmd_i.do_reject;

    if (cmd_i.do_tick && running_q) begin
      if (ticks_q <= CNT_W'(1)) begin
        enter = 1'b1;
        if (load_shadow) begin
          pending_d = 1'b0;
        end
      end else begin
        ticks_d = ticks_q - CNT_W'(1);
      end
    end

    if (cmd_i.do_commit) begin
      if (!en_q) begin
        cur_per_d  = rp_q;
        cur_duty_d = rd_q;
        cur_inv_d  = inv_q;
        running_d  = 1'b0;
        pending_d  = 1'b0;
        ticks_d    = '0;
      end else if (running_q) begin
        sh_per_d  = rp_q;
        sh_duty_d = rd_q;
        sh_inv_d  = inv_q;
        pending_d = 1'b1;
      end else begin
        pending_d = 1'b0;
        enter     = 1'b1;
      end
    end

    if (enter) begin
      cur_per_d  = ep_per;
      cur_duty_d = ep_duty;
      cur_inv_d  = ep_inv;
      phase_d    = ep_level;
      pin_d      = ep_level ^ ep_inv;
      running_d  = !ep_steady;
      ticks_d    = ep_ticks;
    end

    if (cmd_i.do_reject) begin
      status_d = 1'b1;
    end else if (produce) begin
      status_d = 1'b0;
    end

    out_valid_d = produce || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_per_q   <= '0;
      cur_duty_q  <= '0;
      cur_inv_q   <= 1'b0;
      sh_per_q    <= '0;
      sh_duty_q   <= '0;
      sh_inv_q    <= 1'b0;
      phase_q     <= 1'b0;
      running_q   <= 1'b0;
      pending_q   <= 1'b0;
      pin_q       <= 1'b0;
      ticks_q     <= '0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_per_q   <= cur_per_d;
      cur_duty_q  <= cur_duty_d;
      cur_inv_q   <= cur_inv_d;
      sh_per_q    <= sh_per_d;
      sh_duty_q   <= sh_duty_d;
      sh_inv_q    <= sh_inv_d;
      phase_q     <= phase_d;
      running_q   <= running_d;
      pending_q   <= pending_d;
      pin_q       <= pin_d;
      ticks_q     <= ticks_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pin_o            = pin_q;
  assign active_o         = running_q;
  assign update_pending_o = pending_q;
  assign status_o         = status_q;

  a_pending_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> running_q)
    else $error("shadow pending while generator idle");

  a_run_not_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> ((cur_duty_q != '0) && (cur_duty_q != cur_per_q)))
    else $error("generator running with steady duty");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !produce)
    else $error("result overwritten before taken");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (ticks_q == '0))
    else $error("tick counter armed while idle");

endmodule

`default_nettype wire
